// File: src/shp_pkg.sv
`timescale 1ns / 1ps

package shp_pkg;

  // half-step sequence
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_W     = $clog2(PHASE_COUNT);

  // position and revolution width
  localparam int POS_W = 16;
  localparam int NUM_W = 8;
  localparam int COIL_W = 6;

  localparam logic [POS_W-1:0] SPR_RESET = 16'd400;
  localparam logic [POS_W-1:0] SPR_MIN   = 16'd2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // op field codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // mode codes
  typedef enum logic [1:0] {
    MODE_HOME  = 2'd0,
    MODE_SHORT = 2'd1,
    MODE_SLICE = 2'd2,
    MODE_REL   = 2'd3
  } mode_t;

  // classified action carried through the queue
  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_HOME  = 3'd1,
    ACT_SHORT = 3'd2,
    ACT_SLICE = 3'd3,
    ACT_REL   = 3'd4
  } act_t;

  typedef struct packed {
    logic             op;
    logic [1:0]       mode;
    logic             direction;
    logic [NUM_W-1:0] number;
    logic             limit_switch_n;
  } in_item_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil_pattern;
    logic [POS_W-1:0]  position;
    logic              busy_res;
    logic              stepped;
  } out_item_t;

  typedef struct packed {
    act_t             act;
    logic             direction;
    logic [NUM_W-1:0] number;
    logic             limit_switch_n;
  } q_item_t;

  // status of the queue as seen by both sides
  typedef struct packed {
    logic full;
    logic avail;
  } q_status_t;

  // coil drive bits for each half-step phase
  function automatic logic [COIL_W-1:0] drive_bits(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] bits;
    case (ph)
      3'd0:    bits = 6'h18;
      3'd1:    bits = 6'h08;
      3'd2:    bits = 6'h28;
      3'd3:    bits = 6'h20;
      3'd4:    bits = 6'h24;
      3'd5:    bits = 6'h04;
      3'd6:    bits = 6'h14;
      3'd7:    bits = 6'h10;
      default: bits = 6'h00;
    endcase
    return bits;
  endfunction

endpackage

// File: src/shp_front.sv
`timescale 1ns / 1ps

module shp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  shp_pkg::in_item_t   in_data,
  input  shp_pkg::q_status_t  q_status,
  output logic                q_push,
  output shp_pkg::q_item_t    q_wdata
);

  logic             front_valid_r, front_valid_nxt;
  shp_pkg::q_item_t front_item_r, front_item_nxt;
  shp_pkg::q_item_t classified;
  logic             accept;

  // decode op and mode into one action code
  always_comb begin
    classified.direction      = in_data.direction;
    classified.number         = in_data.number;
    classified.limit_switch_n = in_data.limit_switch_n;
    if (in_data.op == shp_pkg::OP_TICK) begin
      classified.act = shp_pkg::ACT_TICK;
    end else begin
      case (shp_pkg::mode_t'(in_data.mode))
        shp_pkg::MODE_HOME:  classified.act = shp_pkg::ACT_HOME;
        shp_pkg::MODE_SHORT: classified.act = shp_pkg::ACT_SHORT;
        shp_pkg::MODE_SLICE: classified.act = shp_pkg::ACT_SLICE;
        shp_pkg::MODE_REL:   classified.act = shp_pkg::ACT_REL;
        default:             classified.act = shp_pkg::ACT_REL;
      endcase
    end
  end

  // hold the item while the queue is full
  assign in_stall = front_valid_r && q_status.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = front_valid_r && !q_status.full;
  assign q_wdata  = front_item_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    front_item_nxt  = front_item_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
      front_item_nxt  = classified;
    end else if (q_push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_item_r <= front_item_nxt;
  end

endmodule

// File: src/shp_queue.sv
`timescale 1ns / 1ps

module shp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  shp_pkg::q_item_t    wdata,
  input  logic                pop,
  output shp_pkg::q_item_t    rdata,
  output shp_pkg::q_status_t  status
);

  shp_pkg::q_item_t              entry_r [shp_pkg::QUEUE_DEPTH];
  logic [shp_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [shp_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [shp_pkg::QCNT_W-1:0]    count_r, count_nxt;

  localparam logic [shp_pkg::QPTR_W-1:0] PTR_LAST = shp_pkg::QPTR_W'(shp_pkg::QUEUE_DEPTH - 1);
  localparam logic [shp_pkg::QCNT_W-1:0] CNT_FULL = shp_pkg::QCNT_W'(shp_pkg::QUEUE_DEPTH);

  assign status.full  = (count_r == CNT_FULL);
  assign status.avail = (count_r != '0);
  assign rdata        = entry_r[rd_ptr_r];

  // advance pointers with wrap at the last entry
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> status.avail)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");
`endif

endmodule

// File: src/shp_back.sv
`timescale 1ns / 1ps

module shp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [shp_pkg::POS_W-1:0]   cfg_wdata,
  input  shp_pkg::q_status_t          q_status,
  input  shp_pkg::q_item_t            q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output shp_pkg::out_item_t          out_data
);

  localparam int PW = shp_pkg::POS_W;

  logic [PW-1:0]                 spr_r;
  logic [shp_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [shp_pkg::COIL_W-1:0]    coil_r, coil_nxt;
  shp_pkg::mode_t                mode_r, mode_nxt;
  logic                          dir_r, dir_nxt;
  logic [PW-1:0]                 target_r, target_nxt;
  logic [shp_pkg::NUM_W-1:0]     left_r, left_nxt;
  logic                          run_r, run_nxt;
  logic                          last_sw_r, last_sw_nxt;
  logic                          out_valid_r, out_valid_nxt;
  shp_pkg::out_item_t            out_data_r, out_data_nxt;

  logic [PW-1:0]                 rev, top, half;
  logic [PW-1:0]                 num_cl, tgt_cl;
  logic                          do_step, step_ccw, stepped;
  logic [PW-1:0]                 pos_step;
  logic [shp_pkg::PHASE_W-1:0]   phase_step;

  // take the next item once the output register is free
  assign q_pop     = q_status.avail && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // revolution limits
  assign rev    = (spr_r < shp_pkg::SPR_MIN) ? shp_pkg::SPR_MIN : spr_r;
  assign top    = rev - 1'b1;
  assign half   = rev >> 1;
  assign num_cl = ({{(PW - shp_pkg::NUM_W){1'b0}}, q_rdata.number} > top) ?
                  top : {{(PW - shp_pkg::NUM_W){1'b0}}, q_rdata.number};
  assign tgt_cl = (target_r > top) ? top : target_r;

  // one half-step in the chosen sense
  always_comb begin
    if (step_ccw) begin
      phase_step = phase_r - 1'b1;
      pos_step   = (pos_r == '0 || pos_r > top) ? top : pos_r - 1'b1;
    end else begin
      phase_step = phase_r + 1'b1;
      pos_step   = (pos_r >= top) ? '0 : pos_r + 1'b1;
    end
  end

  // execute the item against the motion state
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    coil_nxt    = coil_r;
    mode_nxt    = mode_r;
    dir_nxt     = dir_r;
    target_nxt  = target_r;
    left_nxt    = left_r;
    run_nxt     = run_r;
    last_sw_nxt = last_sw_r;
    do_step     = 1'b0;
    step_ccw    = dir_r;

    case (q_rdata.act)
      shp_pkg::ACT_TICK: begin
        if (run_r) begin
          case (mode_r)
            shp_pkg::MODE_HOME: begin
              step_ccw = 1'b0;
              if (!q_rdata.limit_switch_n) begin
                if (!last_sw_r) begin
                  pos_nxt = '0;
                  run_nxt = 1'b0;
                end
                last_sw_nxt = 1'b0;
              end else begin
                last_sw_nxt = 1'b1;
                do_step     = 1'b1;
              end
            end
            shp_pkg::MODE_REL: begin
              do_step  = 1'b1;
              left_nxt = left_r - 1'b1;
              run_nxt  = (left_r != {{(shp_pkg::NUM_W-1){1'b0}}, 1'b1});
            end
            default: begin
              target_nxt = tgt_cl;
              if (pos_r == tgt_cl) begin
                run_nxt = 1'b0;
              end else begin
                do_step = 1'b1;
                run_nxt = (pos_step != tgt_cl);
              end
            end
          endcase
        end
      end
      shp_pkg::ACT_HOME: begin
        if (!run_r) begin
          mode_nxt    = shp_pkg::MODE_HOME;
          last_sw_nxt = 1'b1;
          run_nxt     = 1'b1;
        end
      end
      shp_pkg::ACT_SHORT: begin
        if (!run_r) begin
          mode_nxt   = shp_pkg::MODE_SHORT;
          target_nxt = num_cl;
          if (num_cl > pos_r) begin
            dir_nxt = ((num_cl - pos_r) < half) ? 1'b0 : 1'b1;
          end else begin
            dir_nxt = ((pos_r - num_cl) < half) ? 1'b1 : 1'b0;
          end
          run_nxt = (num_cl != pos_r);
        end
      end
      shp_pkg::ACT_SLICE: begin
        if (!run_r) begin
          mode_nxt   = shp_pkg::MODE_SLICE;
          target_nxt = num_cl;
          dir_nxt    = !(num_cl > pos_r);
          run_nxt    = (num_cl != pos_r);
        end
      end
      shp_pkg::ACT_REL: begin
        if (!run_r) begin
          mode_nxt = shp_pkg::MODE_REL;
          dir_nxt  = q_rdata.direction;
          left_nxt = q_rdata.number;
          run_nxt  = (q_rdata.number != '0);
        end
      end
      default: begin
      end
    endcase

    if (do_step) begin
      phase_nxt = phase_step;
      pos_nxt   = pos_step;
      coil_nxt  = shp_pkg::drive_bits(phase_step);
    end
    stepped = do_step;
  end

  // build the result and drop it once taken
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.coil_pattern = coil_nxt;
      out_data_nxt.position     = pos_nxt;
      out_data_nxt.busy_res     = run_nxt;
      out_data_nxt.stepped      = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r       <= shp_pkg::SPR_RESET;
      phase_r     <= '0;
      pos_r       <= '0;
      coil_r      <= '0;
      mode_r      <= shp_pkg::MODE_HOME;
      dir_r       <= 1'b0;
      target_r    <= '0;
      left_r      <= '0;
      run_r       <= 1'b0;
      last_sw_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        spr_r <= cfg_wdata;
      end
      if (q_pop) begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        coil_r    <= coil_nxt;
        mode_r    <= mode_nxt;
        dir_r     <= dir_nxt;
        target_r  <= target_nxt;
        left_r    <= left_nxt;
        run_r     <= run_nxt;
        last_sw_r <= last_sw_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_step_moves_coils: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && stepped) |=> (coil_r != $past(coil_r)))
    else $error("step left the coil pattern unchanged");

  a_home_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_rdata.act == shp_pkg::ACT_TICK && run_r && mode_r == shp_pkg::MODE_HOME
     && !q_rdata.limit_switch_n && !last_sw_r) |=> (pos_r == '0 && !run_r))
    else $error("confirmed home did not zero the position");

  a_idle_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !run_r) |-> !stepped)
    else $error("step while idle");
`endif

endmodule

// File: src/stepper_half_step_positioner.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  shp_pkg::in_item_t  (op, mode, direction, number, switch)
// out_     output     out_valid/out_stall shp_pkg::out_item_t (coils, position, busy, stepped)
// cfg_     input      cfg_valid/cfg_ready 16-bit steps per revolution
//
// One item per cycle sustained while out_stall stays low; an item's result passes
// through the front register, a queue entry, then execute into the output register.
// The back end runs one item per cycle if not stalled; the two-entry queue absorbs output stalls.
// Synchronous active-low reset; steps per revolution resets to 400, position to home.
// cfg_ready is always high; writes are applied at once.
module stepper_half_step_positioner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  shp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output shp_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [shp_pkg::POS_W-1:0]     cfg_data
);

  logic               q_push, q_pop;
  shp_pkg::q_item_t   q_wdata, q_rdata;
  shp_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;

  // accept and classify
  shp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // decouple front from back
  shp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // execute motion and hold the result
  shp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .q_status  (q_status),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/stepper_half_step_positioner_test.sv
`timescale 1ns / 1ps

module stepper_half_step_positioner_test;

  localparam int QUIET_LIMIT = 4000;
  localparam int PLAN_ROWS   = 27;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 64;

  // short names for the codes used in the directed table
  localparam logic          OPT = shp_pkg::OP_TICK;
  localparam logic          OPS = shp_pkg::OP_START;
  localparam shp_pkg::mode_t MH  = shp_pkg::MODE_HOME;
  localparam shp_pkg::mode_t MSH = shp_pkg::MODE_SHORT;
  localparam shp_pkg::mode_t MSL = shp_pkg::MODE_SLICE;
  localparam shp_pkg::mode_t MR  = shp_pkg::MODE_REL;

  localparam logic [shp_pkg::COIL_W-1:0] COIL_TABLE [8] = '{
    6'h18, 6'h08, 6'h28, 6'h20, 6'h24, 6'h04, 6'h14, 6'h10
  };

  // steps per revolution and idling for each random phase
  localparam logic [15:0] PHASE_SPR   [PHASES] = '{
    16'd400, 16'd2, 16'd65535, 16'd0, 16'd1, 16'd5, 16'd256, 16'd100, 16'd255
  };
  localparam int          PHASE_GAP   [PHASES] = '{0, 52, 0, 37, 0, 52, 0, 37, 0};
  localparam int          PHASE_STALL [PHASES] = '{0, 0, 52, 37, 0, 0, 52, 37, 0};

  typedef struct {
    logic               is_cfg;
    logic [15:0]        spr;
    shp_pkg::in_item_t  cmd;
    logic               typed;
    shp_pkg::out_item_t res;
  } plan_row_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  shp_pkg::in_item_t         in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  shp_pkg::out_item_t        out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [shp_pkg::POS_W-1:0] cfg_data  = '0;

  // motor model state
  logic [15:0]                spr_reg    = shp_pkg::SPR_RESET;
  logic [2:0]                 mot_phase  = 3'd0;
  logic [15:0]                mot_pos    = 16'd0;
  logic [shp_pkg::COIL_W-1:0] coil_drive = '0;
  shp_pkg::mode_t             cur_mode   = shp_pkg::MODE_HOME;
  logic                       cur_dir    = 1'b0;
  logic [15:0]                goal       = 16'd0;
  logic [7:0]                 count_left = 8'd0;
  logic                       moving     = 1'b0;
  logic                       last_sw    = 1'b1;

  shp_pkg::out_item_t pending_results [$];
  shp_pkg::out_item_t oldest;
  plan_row_t          plan [PLAN_ROWS];
  int                 gap_pct      = 0;
  int                 stall_pct    = 0;
  int                 fails        = 0;
  int                 items_sent   = 0;
  int                 results_seen = 0;
  int                 cfg_writes   = 0;
  int                 homes_done   = 0;
  int                 quiet        = 0;

  stepper_half_step_positioner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // revolution size as the block uses it
  function automatic logic [15:0] rev_size();
    return (spr_reg < shp_pkg::SPR_MIN) ? shp_pkg::SPR_MIN : spr_reg;
  endfunction

  // advance one half-step and wrap the position
  task automatic step_motor(input logic ccw);
    logic [15:0] top;
    top = rev_size() - 16'd1;
    if (ccw) begin
      mot_phase = mot_phase - 3'd1;
      if (mot_pos == 16'd0 || mot_pos > top) mot_pos = top;
      else mot_pos = mot_pos - 16'd1;
    end else begin
      mot_phase = mot_phase + 3'd1;
      if (mot_pos >= top) mot_pos = 16'd0;
      else mot_pos = mot_pos + 16'd1;
    end
    coil_drive = COIL_TABLE[mot_phase];
  endtask

  // work out the result of one item and update the motor state
  task automatic predict_motion(input shp_pkg::in_item_t it, output shp_pkg::out_item_t res);
    logic [15:0] top;
    logic [15:0] half;
    logic        stp;
    top  = rev_size() - 16'd1;
    half = rev_size() >> 1;
    stp  = 1'b0;
    if (it.op == shp_pkg::OP_START) begin
      if (!moving) begin
        cur_mode = shp_pkg::mode_t'(it.mode);
        case (cur_mode)
          shp_pkg::MODE_HOME: begin
            last_sw = 1'b1;
            moving  = 1'b1;
          end
          shp_pkg::MODE_SHORT: begin
            goal = {8'd0, it.number};
            if (goal > top) goal = top;
            if (goal > mot_pos) cur_dir = ((goal - mot_pos) < half) ? 1'b0 : 1'b1;
            else cur_dir = ((mot_pos - goal) < half) ? 1'b1 : 1'b0;
            moving = (goal != mot_pos);
          end
          shp_pkg::MODE_SLICE: begin
            goal = {8'd0, it.number};
            if (goal > top) goal = top;
            cur_dir = (goal > mot_pos) ? 1'b0 : 1'b1;
            moving  = (goal != mot_pos);
          end
          default: begin
            cur_dir    = it.direction;
            count_left = it.number;
            moving     = (it.number != 8'd0);
          end
        endcase
      end
    end else if (moving) begin
      case (cur_mode)
        shp_pkg::MODE_HOME: begin
          if (!it.limit_switch_n) begin
            // second pressed reading in a row: home reached
            if (!last_sw) begin
              mot_pos = 16'd0;
              moving  = 1'b0;
              homes_done++;
            end
            last_sw = 1'b0;
          end else begin
            last_sw = 1'b1;
            step_motor(1'b0);
            stp = 1'b1;
          end
        end
        shp_pkg::MODE_REL: begin
          step_motor(cur_dir);
          count_left = count_left - 8'd1;
          moving     = (count_left != 8'd0);
          stp        = 1'b1;
        end
        default: begin
          if (goal > top) goal = top;
          if (mot_pos == goal) begin
            moving = 1'b0;
          end else begin
            step_motor(cur_dir);
            moving = (mot_pos != goal);
            stp    = 1'b1;
          end
        end
      endcase
    end
    res.coil_pattern = coil_drive;
    res.position     = mot_pos;
    res.busy_res     = moving;
    res.stepped      = stp;
  endtask

  // offer one item, wait for it to be taken, queue its expected result
  task automatic send_item(input shp_pkg::in_item_t it, input logic typed,
                           input shp_pkg::out_item_t typed_res);
    shp_pkg::out_item_t res;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_motion(it, res);
    pending_results.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // write steps per revolution once the pipeline has drained
  task automatic write_spr(input logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    spr_reg = v;
    cfg_writes++;
  endtask

  // mostly whole moves: a command, then ticks until the motor stops
  task automatic random_items(input int count);
    int                sent;
    int                ticks;
    int                pick;
    int                tgt;
    shp_pkg::in_item_t it;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        it = $bits(shp_pkg::in_item_t)'($urandom);
        send_item(it, 1'b0, '0);
        sent++;
      end else begin
        it.op             = shp_pkg::OP_START;
        it.mode           = 2'($urandom_range(3));
        it.direction      = 1'($urandom_range(1));
        it.limit_switch_n = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 20) begin
          it.number = 8'd0;
        end else if (pick < 30) begin
          it.number = 8'd255;
        end else if (pick < 55) begin
          it.number = 8'($urandom_range(1, 8));
        end else if (pick < 75) begin
          // target about half a revolution away
          tgt = (int'(mot_pos) + int'(rev_size()) / 2 + int'($urandom_range(2)) - 1)
                % int'(rev_size());
          it.number = (tgt < 256) ? 8'(tgt) : 8'($urandom_range(255));
        end else begin
          it.number = 8'($urandom_range(255));
        end
        send_item(it, 1'b0, '0);
        sent++;
        ticks = 0;
        while (moving && ticks < 300 && sent < count) begin
          it = $bits(shp_pkg::in_item_t)'($urandom);
          // now and then a command that the busy motor drops
          it.op = ($urandom_range(99) < 8) ? shp_pkg::OP_START : shp_pkg::OP_TICK;
          it.limit_switch_n = ($urandom_range(99) >= 30);
          send_item(it, 1'b0, '0);
          sent++;
          ticks++;
        end
      end
    end
  endtask

  // drive a fresh receiver stall decision each cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no item waiting: %p", out_data);
        fails++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.coil_pattern !== oldest.coil_pattern) begin
          $error("coil_pattern: expected %h, got %h", oldest.coil_pattern,
                 out_data.coil_pattern);
          fails++;
        end
        if (out_data.position !== oldest.position) begin
          $error("position: expected %0d, got %0d", oldest.position, out_data.position);
          fails++;
        end
        if (out_data.busy_res !== oldest.busy_res) begin
          $error("busy_res: expected %b, got %b", oldest.busy_res, out_data.busy_res);
          fails++;
        end
        if (out_data.stepped !== oldest.stepped) begin
          $error("stepped: expected %b, got %b", oldest.stepped, out_data.stepped);
          fails++;
        end
      end
    end
  end

  // end the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] spr_v;
    plan = '{
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b1, '{6'h00, 16'd0,   1'b0, 1'b0}},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b0}, 1'b1, '{6'h00, 16'd0,   1'b0, 1'b0}},
      '{1'b0, 16'd0, '{OPS, MR,  1'b0, 8'd0,   1'b1}, 1'b1, '{6'h00, 16'd0,   1'b0, 1'b0}},
      '{1'b0, 16'd0, '{OPS, MSH, 1'b0, 8'd0,   1'b1}, 1'b1, '{6'h00, 16'd0,   1'b0, 1'b0}},
      '{1'b0, 16'd0, '{OPS, MSL, 1'b1, 8'd0,   1'b0}, 1'b1, '{6'h00, 16'd0,   1'b0, 1'b0}},
      '{1'b0, 16'd0, '{OPS, MR,  1'b1, 8'd3,   1'b1}, 1'b1, '{6'h00, 16'd0,   1'b1, 1'b0}},
      '{1'b0, 16'd0, '{OPS, MSH, 1'b0, 8'd255, 1'b1}, 1'b1, '{6'h00, 16'd0,   1'b1, 1'b0}},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b1, '{6'h10, 16'd399, 1'b1, 1'b1}},
      '{1'b0, 16'd0, '{OPT, MSL, 1'b0, 8'd255, 1'b0}, 1'b1, '{6'h14, 16'd398, 1'b1, 1'b1}},
      '{1'b0, 16'd0, '{OPT, MH,  1'b1, 8'd0,   1'b1}, 1'b1, '{6'h04, 16'd397, 1'b0, 1'b1}},
      '{1'b0, 16'd0, '{OPS, MH,  1'b0, 8'd0,   1'b0}, 1'b1, '{6'h04, 16'd397, 1'b1, 1'b0}},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b1, '{6'h14, 16'd398, 1'b1, 1'b1}},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b0}, 1'b1, '{6'h14, 16'd398, 1'b1, 1'b0}},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b1, '{6'h10, 16'd399, 1'b1, 1'b1}},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b0}, 1'b1, '{6'h10, 16'd399, 1'b1, 1'b0}},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b0}, 1'b1, '{6'h10, 16'd0,   1'b0, 1'b0}},
      '{1'b0, 16'd0, '{OPS, MSH, 1'b0, 8'd2,   1'b1}, 1'b0, '0},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b0, '0},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b0, '0},
      '{1'b1, 16'd2, '0, 1'b0, '0},
      '{1'b0, 16'd0, '{OPS, MSL, 1'b0, 8'd255, 1'b1}, 1'b0, '0},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b0, '0},
      '{1'b0, 16'd0, '{OPS, MSH, 1'b0, 8'd0,   1'b1}, 1'b0, '0},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b0, '0},
      '{1'b1, 16'd0, '0, 1'b0, '0},
      '{1'b0, 16'd0, '{OPS, MR,  1'b1, 8'd1,   1'b0}, 1'b0, '0},
      '{1'b0, 16'd0, '{OPT, MH,  1'b0, 8'd0,   1'b1}, 1'b0, '0}
    };

    // hold reset, then release it on a rising edge
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table with no idling
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_spr(plan[i].spr);
      else send_item(plan[i].cmd, plan[i].typed, plan[i].res);
    end

    // random phases, each with its own revolution size and idling
    for (int p = 0; p < PHASES; p++) begin
      spr_v = PHASE_SPR[p];
      if (p == 5) spr_v = 16'($urandom_range(3, 12));
      if (p == 7) spr_v = 16'($urandom_range(13, 600));
      write_spr(spr_v);
      gap_pct   = PHASE_GAP[p];
      stall_pct = PHASE_STALL[p];
      random_items(PHASE_ITEMS);
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fails++;
    end

    $display("Ran %0d items, checked %0d results, %0d revolution size writes",
             items_sent, results_seen, cfg_writes);
    $display("Homing completed %0d times; idling phases covered sender, receiver and both",
             homes_done);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
